// ===== design/bdv_pkg.sv =====
// ----------------------------------------------------------------------------
// bdv_pkg
// Shared types, constants and helper functions for the base64 decode and
// validate core.
// ----------------------------------------------------------------------------
package bdv_pkg;

	localparam int CHAR_W    = 8;
	localparam int SEXTET_W  = 6;
	localparam int ACC_W     = 12;
	localparam int HELD_W    = 3;
	localparam int CNT_W     = 17;
	localparam int MAX_IN_W  = 17;
	localparam int MAX_OUT_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 17;

	localparam logic [CNT_W-1:0]     CNT_MAX       = '1;
	localparam logic [MAX_IN_W-1:0]  MAX_IN_RST    = MAX_IN_W'(64 * 1024);
	localparam logic [MAX_OUT_W-1:0] MAX_OUT_RST   = MAX_OUT_W'(32 * 1024);

	// certificate header marker searched for in the decoded bytes
	localparam int MARK_LEN = 27;
	localparam int MPOS_W   = 5;
	localparam logic [8*MARK_LEN-1:0] MARK_TEXT = "-----BEGIN CERTIFICATE-----";
	localparam logic [CHAR_W-1:0] CH_DASH = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_PAD  = 8'h3d;
	// length of the leading dash run of the marker
	localparam logic [MPOS_W-1:0] DASH_RUN = MPOS_W'(5);

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CL_DATA = 2'd0,
		CL_PAD  = 2'd1,
		CL_BAD  = 2'd2
	} char_class_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_PAD  = 2'd2,
		ERR_CHAR = 2'd3
	} stream_err_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEN  = 3'd1,
		ST_BAD_PAD  = 3'd2,
		ST_BAD_CHAR = 3'd3,
		ST_NO_HDR   = 3'd4,
		ST_OUT_LONG = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_IN  = 1'b0,
		REG_MAX_OUT = 1'b1
	} cfg_reg_t;

	// one classified character, front to back
	typedef struct packed {
		char_class_t         cls;
		logic [SEXTET_W-1:0] sextet;
		logic                last;
	} q_entry_t;

	// one result item
	typedef struct packed {
		logic [CHAR_W-1:0] data_byte;
		logic              byte_valid;
		logic              done_res;
		status_t           status;
	} res_t;

	// sextet value of an alphabet character
	function automatic logic [SEXTET_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
		logic [SEXTET_W-1:0] v;
		v = '0;
		case (c) inside
			[8'h41:8'h5a]: v = SEXTET_W'(c - 8'h41);
			[8'h61:8'h7a]: v = SEXTET_W'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: v = SEXTET_W'(c - 8'h30 + 8'd52);
			8'h2b:         v = SEXTET_W'(62);
			8'h2f:         v = SEXTET_W'(63);
			default:       v = '0;
		endcase
		return v;
	endfunction

	function automatic char_class_t class_of(input logic [CHAR_W-1:0] c);
		char_class_t k;
		k = CL_BAD;
		case (c) inside
			[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39], 8'h2b, 8'h2f: k = CL_DATA;
			CH_PAD:  k = CL_PAD;
			default: k = CL_BAD;
		endcase
		return k;
	endfunction

	function automatic logic [CHAR_W-1:0] mark_char(input logic [MPOS_W-1:0] j);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		for (int i = 0; i < MARK_LEN; i++) begin
			if (j == MPOS_W'(i))
				ch = MARK_TEXT[8*(MARK_LEN-1-i) +: 8];
		end
		return ch;
	endfunction

	// Matcher step. The marker's only self overlap is its leading dash run,
	// so a mismatch falls back to the dash run, one dash, or zero.
	function automatic logic [MPOS_W-1:0] mark_next(input logic [MPOS_W-1:0] pos,
			input logic [CHAR_W-1:0] b);
		logic [MPOS_W-1:0] j;
		logic [MPOS_W-1:0] n;
		j = (pos >= MPOS_W'(MARK_LEN)) ? '0 : pos;
		if (mark_char(j) == b)
			n = j + 1'b1;
		else if (b == CH_DASH)
			n = (j == DASH_RUN) ? DASH_RUN : MPOS_W'(1);
		else
			n = '0;
		return n;
	endfunction

endpackage

// ===== design/bdv_in_if.sv =====
// ----------------------------------------------------------------------------
// bdv_in_if
// Encoded character channel: valid/ready with character and last mark.
// ----------------------------------------------------------------------------
interface bdv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== design/bdv_out_if.sv =====
// ----------------------------------------------------------------------------
// bdv_out_if
// Result channel: decoded byte and final status.
// ----------------------------------------------------------------------------
interface bdv_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       done_res;
	logic [2:0] status;

	modport source (output valid, output data_byte, output byte_valid,
		output done_res, output status, input ready);
	modport sink   (input valid, input data_byte, input byte_valid,
		input done_res, input status, output ready);
endinterface

// ===== design/bdv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bdv_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bdv_cfg_if;
	import bdv_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bdv_front.sv =====
// ----------------------------------------------------------------------------
// bdv_front
// Accepts encoded characters and classifies them into data, pad or bad,
// with the sextet value, for the queue.
// ----------------------------------------------------------------------------
module bdv_front (
	bdv_in_if.sink            src,
	input  logic              q_full,
	output logic              push,
	output bdv_pkg::q_entry_t push_entry
);
	import bdv_pkg::*;

	assign src.ready = !q_full;
	assign push      = src.valid && !q_full;

	always_comb begin
		push_entry.cls    = class_of(src.character);
		push_entry.sextet = sextet_of(src.character);
		push_entry.last   = src.last;
	end

endmodule

// ===== design/bdv_queue.sv =====
// ----------------------------------------------------------------------------
// bdv_queue
// Short register queue between front and back.
// ----------------------------------------------------------------------------
module bdv_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bdv_pkg::q_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output bdv_pkg::q_entry_t head
);
	import bdv_pkg::*;

	q_entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ===== design/bdv_back.sv =====
// ----------------------------------------------------------------------------
// bdv_back
// Stream state: bit accumulator, error tracking, counters, header matcher,
// final status and the result register.
// ----------------------------------------------------------------------------
module bdv_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bdv_pkg::MAX_IN_W-1:0]    max_in,
	input  logic [bdv_pkg::MAX_OUT_W-1:0]   max_out,
	input  logic                            q_not_empty,
	input  bdv_pkg::q_entry_t               q_head,
	output logic                            pop,
	bdv_out_if.source                       res
);
	import bdv_pkg::*;

	logic [ACC_W-1:0]  acc_q,  acc_n;
	logic [HELD_W-1:0] held_q, held_n;
	logic              pad_q,  pad_n;
	stream_err_t       err_q,  err_n;
	logic [CNT_W-1:0]  cin_q,  cin_n;
	logic [CNT_W-1:0]  cout_q, cout_n;
	logic [MPOS_W-1:0] mpos_q, mpos_n;
	logic              found_q, found_n;

	res_t              res_q;
	res_t              res_n;
	logic              res_v_q;
	logic              take;
	logic              emit;
	logic [HELD_W:0]   held_sum;
	logic              bad_len;

	assign take = !res_v_q || res.ready;
	assign pop  = q_not_empty && take;
	assign emit = pop && (res_n.byte_valid || q_head.last);

	always_comb begin
		acc_n    = acc_q;
		held_n   = held_q;
		pad_n    = pad_q;
		err_n    = err_q;
		cout_n   = cout_q;
		mpos_n   = mpos_q;
		found_n  = found_q;
		held_sum = {1'b0, held_q} + (HELD_W+1)'(SEXTET_W);
		res_n    = '0;
		bad_len  = 1'b0;
		cin_n    = (cin_q == CNT_MAX) ? cin_q : cin_q + 1'b1;

		if (q_head.cls == CL_PAD) begin
			pad_n = 1'b1;
		end else if (err_q == ERR_NONE) begin
			if (pad_q) begin
				err_n = ERR_PAD;
			end else if (q_head.cls == CL_BAD) begin
				err_n = ERR_CHAR;
			end else begin
				acc_n = {acc_q[ACC_W-SEXTET_W-1:0], q_head.sextet};
				if (held_sum >= (HELD_W+1)'(8)) begin
					held_n           = HELD_W'(held_sum - (HELD_W+1)'(8));
					res_n.data_byte  = CHAR_W'(acc_n >> held_n);
					res_n.byte_valid = 1'b1;
					cout_n           = (cout_q == CNT_MAX) ? cout_q : cout_q + 1'b1;
					if (!found_q) begin
						mpos_n = mark_next(mpos_q, res_n.data_byte);
						if (mpos_n >= MPOS_W'(MARK_LEN)) begin
							found_n = 1'b1;
							mpos_n  = '0;
						end
					end
				end else begin
					held_n = held_sum[HELD_W-1:0];
				end
			end
		end

		if (q_head.last) begin
			bad_len = (cin_n == '0) || (cin_n > max_in) || (cin_n[1:0] != 2'b00);
			res_n.done_res = 1'b1;
			if (bad_len)
				res_n.status = ST_BAD_LEN;
			else if (err_n != ERR_NONE)
				res_n.status = status_t'({1'b0, err_n});
			else if (!found_n)
				res_n.status = ST_NO_HDR;
			else if (cout_n > {1'b0, max_out})
				res_n.status = ST_OUT_LONG;
			else
				res_n.status = ST_OK;
			// string ends: state clears for the next one
			acc_n   = '0;
			held_n  = '0;
			pad_n   = 1'b0;
			err_n   = ERR_NONE;
			cin_n   = '0;
			cout_n  = '0;
			mpos_n  = '0;
			found_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			held_q  <= '0;
			pad_q   <= 1'b0;
			err_q   <= ERR_NONE;
			cin_q   <= '0;
			cout_q  <= '0;
			mpos_q  <= '0;
			found_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q   <= acc_n;
				held_q  <= held_n;
				pad_q   <= pad_n;
				err_q   <= err_n;
				cin_q   <= cin_n;
				cout_q  <= cout_n;
				mpos_q  <= mpos_n;
				found_q <= found_n;
			end
			if (emit)
				res_v_q <= 1'b1;
			else if (res.ready)
				res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_q <= res_n;
	end

	assign res.valid      = res_v_q;
	assign res.data_byte  = res_q.data_byte;
	assign res.byte_valid = res_q.byte_valid;
	assign res.done_res   = res_q.done_res;
	assign res.status     = res_q.status;

endmodule

// ===== design/base64_decode_validate_core.sv =====
// ----------------------------------------------------------------------------
// base64_decode_validate_core
// Streaming base64 decoder with certificate blob validation.
// ----------------------------------------------------------------------------
// Path: an accepted character beat is written into the queue; the back stage
//   moves it into the result register when that register is free or drained.
// Throughput: one character per cycle while the queue has room; the back
//   stage consumes one queue entry per cycle whenever the result register is
//   free or being drained.
// Reset: limits go to 65536 input / 32768 output, stream state clears, the
//   queue and the result register come up empty.
// ----------------------------------------------------------------------------
module base64_decode_validate_core (
	input  logic       clk,
	input  logic       arst_n,
	bdv_in_if.sink     src,
	bdv_out_if.source  res,
	bdv_cfg_if.sink    cfg
);
	import bdv_pkg::*;

	// configuration limits
	logic [MAX_IN_W-1:0]  max_in_q;
	logic [MAX_OUT_W-1:0] max_out_q;

	// front to queue
	logic     push;
	q_entry_t push_entry;
	logic     q_full;

	// queue to back
	logic     q_not_empty;
	q_entry_t q_head;
	logic     pop;

	// Config writes are always taken; the user must write only while idle, the block does not enforce it.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_in_q  <= MAX_IN_RST;
			max_out_q <= MAX_OUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MAX_IN:  max_in_q  <= cfg.data[MAX_IN_W-1:0];
				REG_MAX_OUT: max_out_q <= cfg.data[MAX_OUT_W-1:0];
				default:     ;
			endcase
		end
	end

	// Front: accept and classify each character beat.
	bdv_front u_front (
		.src        (src),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Short queue decouples input acceptance from result backpressure.
	bdv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// Back: decode, track errors and header, produce bytes and final status.
	bdv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_in      (max_in_q),
		.max_out     (max_out_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.res         (res)
	);

	// Every result beat carries a byte or ends a string.
	a_res_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.byte_valid || res.done_res))
		else $error("result beat with neither byte nor done");

	// Status is only meaningful on the final beat.
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.done_res) |-> (res.status == ST_OK))
		else $error("status set on a non-final beat");

	// A stalled result beat must not change while the back stage keeps running.
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.data_byte)
			&& $stable(res.status) && $stable(res.done_res)))
		else $error("result register changed under stall");

endmodule

// ===== tb/bdv_decode_checker.sv =====
// ----------------------------------------------------------------------------
// bdv_decode_checker
// Watches the character, result and register channels of the base64 decode
// and validate core, predicts every result beat and compares field by field.
// ----------------------------------------------------------------------------
module bdv_decode_checker (
	input  logic clk,
	input  logic arst_n,
	bdv_in_if    src,
	bdv_out_if   res,
	bdv_cfg_if   cfg,
	output int   fails,
	output int   in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	import bdv_pkg::*;

	localparam logic [7:0]  PAD_CHAR   = 8'h3d;
	localparam int          HDR_LEN    = 27;
	localparam logic [16:0] COUNT_TOP  = 17'h1ffff;
	localparam int          REPORT_MAX = 10;

	string hdr_text = "-----BEGIN CERTIFICATE-----";

	// limits as last written
	logic [16:0] lim_in;
	logic [15:0] lim_out;

	// stream state, cleared at reset and after each last character
	logic [11:0] acc;
	int          held;
	bit          pad_seen;
	stream_err_t first_err;
	logic [16:0] chars_seen;
	logic [16:0] bytes_out;
	int          hdr_pos;
	bit          hdr_found;

	res_t pending_results[$];

	initial begin
		fails     = 0;
		in_flight = 0;
	end

	function automatic void add_expected(input res_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void clear_stream();
		acc        = '0;
		held       = 0;
		pad_seen   = 1'b0;
		first_err  = ERR_NONE;
		chars_seen = '0;
		bytes_out  = '0;
		hdr_pos    = 0;
		hdr_found  = 1'b0;
	endfunction

	function automatic bit b64_sextet(input logic [7:0] c, output logic [5:0] v);
		v = '0;
		if (c >= "A" && c <= "Z")
			v = 6'(c - "A");
		else if (c >= "a" && c <= "z")
			v = 6'(c - "a" + 8'd26);
		else if (c >= "0" && c <= "9")
			v = 6'(c - "0" + 8'd52);
		else if (c == "+")
			v = 6'd62;
		else if (c == "/")
			v = 6'd63;
		else
			return 1'b0;
		return 1'b1;
	endfunction

	// streaming header search: on a miss, fall back to the longest prefix
	// that still ends in the new byte
	function automatic void hdr_step(input logic [7:0] b);
		int j;
		int nxt;
		bit agree;
		j   = (hdr_pos >= HDR_LEN) ? 0 : hdr_pos;
		nxt = 0;
		if (hdr_text[j] == b) begin
			nxt = j + 1;
		end else begin
			for (int k = j; k >= 1; k--) begin
				if (hdr_text[k-1] == b) begin
					agree = 1'b1;
					for (int i = 0; i < k - 1; i++)
						if (hdr_text[i] != hdr_text[j-k+1+i])
							agree = 1'b0;
					if (agree) begin
						nxt = k;
						break;
					end
				end
			end
		end
		if (nxt >= HDR_LEN) begin
			hdr_found = 1'b1;
			nxt = 0;
		end
		hdr_pos = nxt;
	endfunction

	function automatic status_t final_status();
		if (chars_seen == '0 || chars_seen > lim_in || chars_seen[1:0] != 2'b00)
			return ST_BAD_LEN;
		if (first_err == ERR_PAD)
			return ST_BAD_PAD;
		if (first_err == ERR_CHAR)
			return ST_BAD_CHAR;
		if (!hdr_found)
			return ST_NO_HDR;
		if (bytes_out > {1'b0, lim_out})
			return ST_OUT_LONG;
		return ST_OK;
	endfunction

	task automatic predict_char(input logic [7:0] c, input logic is_last);
		logic [5:0] six;
		res_t r;
		r = '0;
		if (chars_seen != COUNT_TOP)
			chars_seen++;
		if (c == PAD_CHAR) begin
			pad_seen = 1'b1;
		end else if (first_err == ERR_NONE) begin
			if (pad_seen) begin
				first_err = ERR_PAD;
			end else if (!b64_sextet(c, six)) begin
				first_err = ERR_CHAR;
			end else begin
				acc  = {acc[5:0], six};
				held = held + 6;
				if (held >= 8) begin
					held         = held - 8;
					r.data_byte  = 8'(acc >> held);
					r.byte_valid = 1'b1;
					if (bytes_out != COUNT_TOP)
						bytes_out++;
					if (!hdr_found)
						hdr_step(r.data_byte);
				end
			end
		end
		if (is_last) begin
			r.done_res = 1'b1;
			r.status   = final_status();
			clear_stream();
		end
		if (r.byte_valid || r.done_res)
			add_expected(r);
	endtask

	task automatic report(input string what, input bit has_want, input res_t want);
		fails++;
		if (fails <= REPORT_MAX) begin
			if (has_want)
				$display("[%0t] %s: exp byte=%02h v=%0b done=%0b st=%0d, got byte=%02h v=%0b done=%0b st=%0d",
					$realtime, what, want.data_byte, want.byte_valid, want.done_res,
					want.status, res.data_byte, res.byte_valid, res.done_res, res.status);
			else
				$display("[%0t] %s: got byte=%02h v=%0b done=%0b st=%0d", $realtime, what,
					res.data_byte, res.byte_valid, res.done_res, res.status);
		end
	endtask

	always @(posedge clk) begin : watch
		res_t want;
		if (!arst_n) begin
			lim_in  = MAX_IN_RST;
			lim_out = MAX_OUT_RST;
			clear_stream();
			pending_results.delete();
		end else begin
			// results first: a result never belongs to a character taken at the same edge
			if (res.valid && res.ready) begin
				if (pending_results.size() == 0) begin
					report("result with nothing expected", 1'b0, '0);
				end else begin
					want = pending_results.pop_front();
					if (res.data_byte !== want.data_byte || res.byte_valid !== want.byte_valid ||
							res.done_res !== want.done_res || res.status !== want.status)
						report("result mismatch", 1'b1, want);
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_MAX_IN)
					lim_in = cfg.data;
				else
					lim_out = cfg.data[15:0];
			end
			if (src.valid && src.ready)
				predict_char(src.character, src.last);
		end
		in_flight = pending_results.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the base64 decode and validate core: directed
// strings, random certificate-like blobs, short strings and noise under
// several limit settings, then a stretch at full rate with no stalls.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bdv_pkg::*;

	typedef logic [7:0] octet_t;

	localparam logic [7:0] PAD_CHAR       = 8'h3d;
	localparam int         PHASE_CHARS    = 200;     // random beats per limit setting
	localparam int         LONG_HOLD      = 400;     // receiver hold-off, cycles
	localparam int         SETTLE         = 4;       // > queue drain time, cycles
	localparam int         WATCHDOG_LIMIT = 4000;    // cycles without any beat

	logic clk = 1'b0;
	logic arst_n;

	bdv_in_if  src_if ();
	bdv_out_if res_if ();
	bdv_cfg_if cfg_if ();

	int fail_total;
	int in_flight;

	base64_decode_validate_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	bdv_decode_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.src       (src_if),
		.res       (res_if),
		.cfg       (cfg_if),
		.fails     (fail_total),
		.in_flight (in_flight)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	string  b64_set  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	string  hdr_text = "-----BEGIN CERTIFICATE-----";

	octet_t raw_bytes[$];   // decoded payload being built
	octet_t enc_text[$];    // character string about to be sent

	function automatic void add_raw(input octet_t b);
		raw_bytes.insert(raw_bytes.size(), b);
	endfunction

	function automatic void add_enc(input octet_t c);
		enc_text.insert(enc_text.size(), c);
	endfunction

	// sender and receiver controls
	int burst_left = 0;
	bit tx_steady  = 1'b0;  // no sender gaps
	bit rx_free    = 1'b0;  // receiver never stalls
	bit hold_req   = 1'b0;  // asks the receiver for one long hold-off

	// ------------------------------------------------------------------------
	// Receiver: alternating ready and stall stretches of random length, now
	// and then a long stretch with no stall. A hold request makes it drop
	// ready while a hold-off counter kept here, loaded from LONG_HOLD, runs
	// down, so the core backs up into the character channel while the sender keeps offering.
	// ------------------------------------------------------------------------
	initial begin : rx_pattern
		int left;
		int hold_left;
		bit on;
		left         = 0;
		hold_left    = 0;
		on           = 1'b0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (rx_free) begin
				res_if.ready <= 1'b1;
			end else begin
				if (left == 0) begin
					on   = !on;
					left = on ? $urandom_range(1, 24) : $urandom_range(1, 5);
					if (on && $urandom_range(0, 7) == 0)
						left = 80;
				end
				left--;
				res_if.ready <= on;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any beat on any channel restarts the count.
	// ------------------------------------------------------------------------
	int quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || (src_if.valid && src_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Character beats. Entered and left at a falling edge. The sender runs in
	// bursts; between bursts valid drops for a random gap.
	// ------------------------------------------------------------------------
	task automatic send_char(input logic [7:0] c, input logic is_last);
		int gap;
		if (burst_left == 0 && !tx_steady) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
			if (gap > 0) begin
				src_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		if (burst_left > 0)
			burst_left--;
		src_if.valid     <= 1'b1;
		src_if.character <= c;
		src_if.last      <= is_last;
		@(posedge clk);
		while (!src_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_text();
		for (int i = 0; i < enc_text.size(); i++)
			send_char(enc_text[i], i == enc_text.size() - 1);
	endtask

	// stop offering and wait until every predicted result has come back,
	// plus a SETTLE wait for characters that produce no result
	task automatic drain();
		src_if.valid <= 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// writes both limits back to back; valid stays high between the beats
	task automatic set_limits(input logic [16:0] in_lim, input logic [16:0] out_lim);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= REG_MAX_IN;
		cfg_if.data  <= in_lim;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.index <= REG_MAX_OUT;
		cfg_if.data  <= out_lim;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// String builders
	// ------------------------------------------------------------------------
	function automatic void encode_bytes();
		int n;
		logic [23:0] grp;
		enc_text.delete();
		for (int i = 0; i < raw_bytes.size(); i += 3) begin
			n = raw_bytes.size() - i;
			if (n > 3)
				n = 3;
			grp = {raw_bytes[i], (n > 1) ? raw_bytes[i+1] : 8'h00,
				(n > 2) ? raw_bytes[i+2] : 8'h00};
			add_enc(b64_set[grp[23:18]]);
			add_enc(b64_set[grp[17:12]]);
			add_enc((n > 1) ? octet_t'(b64_set[grp[11:6]]) : PAD_CHAR);
			add_enc((n > 2) ? octet_t'(b64_set[grp[5:0]]) : PAD_CHAR);
		end
	endfunction

	// Certificate-like payload: filler made of random bytes, dash runs and
	// partial headers (to exercise the matcher's fallback), usually with the
	// full header dropped in at a random offset.
	function automatic void build_cert();
		int target;
		int fill;
		int n;
		int p;
		bit with_hdr;
		raw_bytes.delete();
		target   = $urandom_range(27, 48);
		with_hdr = $urandom_range(0, 4) != 0;
		fill     = with_hdr ? target - 27 : target;
		while (raw_bytes.size() < fill) begin
			case ($urandom_range(0, 3))
				0: add_raw(octet_t'($urandom_range(0, 255)));
				1: begin
					n = $urandom_range(1, 7);
					repeat (n) add_raw("-");
				end
				2: begin
					n = $urandom_range(1, 26);
					for (int i = 0; i < n; i++)
						add_raw(hdr_text[i]);
				end
				default: add_raw(b64_set[$urandom_range(0, 63)]);
			endcase
		end
		while (raw_bytes.size() > fill)
			void'(raw_bytes.pop_back());
		if (with_hdr) begin
			p = $urandom_range(0, raw_bytes.size());
			for (int i = 0; i < 27; i++)
				raw_bytes.insert(p + i, hdr_text[i]);
		end
	endfunction

	function automatic void build_short();
		raw_bytes.delete();
		repeat ($urandom_range(1, 9))
			add_raw(octet_t'($urandom_range(0, 255)));
	endfunction

	// raw characters: any byte, alphabet or padding, random length
	function automatic void build_noise();
		enc_text.delete();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 2))
				0: add_enc(octet_t'($urandom_range(0, 255)));
				1: add_enc(b64_set[$urandom_range(0, 63)]);
				default: add_enc(PAD_CHAR);
			endcase
		end
	endfunction

	// break a well-formed string: bad byte, data after padding, wrong length,
	// or padding in the middle
	function automatic void mutate();
		int pos;
		pos = $urandom_range(0, enc_text.size() - 1);
		case ($urandom_range(0, 3))
			0: enc_text[pos] = octet_t'($urandom_range(0, 255));
			1: add_enc(b64_set[$urandom_range(0, 63)]);
			2: if (enc_text.size() > 1) enc_text.delete(pos);
			default: enc_text[pos] = PAD_CHAR;
		endcase
	endfunction

	// Mostly well-formed strings with random content, the rest noise and
	// broken strings. Optionally one long receiver hold-off half way.
	task automatic random_phase(input bit with_hold);
		int sent;
		int sel;
		bit hold_asked;
		sent       = 0;
		hold_asked = 1'b0;
		while (sent < PHASE_CHARS) begin
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				build_cert();
				encode_bytes();
			end else if (sel < 8) begin
				build_short();
				encode_bytes();
			end else begin
				build_noise();
			end
			if (sel < 8 && $urandom_range(0, 5) == 0)
				mutate();
			if (with_hold && !hold_asked && sent >= PHASE_CHARS / 2) begin
				hold_req   = 1'b1;
				hold_asked = 1'b1;
			end
			send_text();
			sent += enc_text.size();
			// sender pause until the core has emptied out
			if ($urandom_range(0, 15) == 0)
				drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		arst_n           = 1'b0;
		src_if.valid     = 1'b0;
		src_if.character = '0;
		src_if.last      = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = REG_MAX_IN;
		cfg_if.data      = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset limits
		send_str("QUJD");       // "ABC": good length, no header
		send_str("A");          // length one
		send_str("AB=C");       // data after padding
		send_str("AB==");       // proper padding, no header
		send_str("A*BC");       // byte outside the alphabet, counting goes on
		send_char(8'h00, 1'b0); // extremes of the character field
		send_char(8'hff, 1'b0);
		send_str("z9");
		send_str("+/+/");       // top of the alphabet
		drain();
		random_phase(1'b0);

		// mid limits, with the long receiver hold-off
		drain();
		set_limits(17'd48, 17'd30);
		random_phase(1'b1);

		// smallest legal limits
		drain();
		set_limits(17'd4, 17'd1);
		random_phase(1'b0);

		// zero limits: everything is bad length
		drain();
		set_limits(17'd0, 17'd0);
		random_phase(1'b0);

		// all ones; the top bit of the output limit write is dropped
		drain();
		set_limits(17'h1ffff, 17'h1ffff);
		random_phase(1'b0);

		// random small limits
		drain();
		set_limits(17'($urandom_range(4, 80)), 17'($urandom_range(1, 50)));
		random_phase(1'b0);

		// full rate on both sides: no sender gaps, no receiver stalls
		drain();
		set_limits(17'd65536, 17'd32768);
		tx_steady = 1'b1;
		rx_free   = 1'b1;
		random_phase(1'b0);
		drain();
		tx_steady = 1'b0;
		rx_free   = 1'b0;
		repeat (20) @(negedge clk);

		if (fail_total == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
